/* rtl/rcy_pkg.sv */
// shared types, constants and saturating arithmetic for the ray/cylinder intersect block
package rcy_pkg;

    localparam int QW = 64;
    typedef logic signed [QW-1:0] t_q;

    localparam t_q                  Q_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [QW:0]  LIM_W = 65'sh0_3FFF_FFFF_FFFF_FFFF;

    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_CENTER_Z,
        CFG_AXIS_X,
        CFG_AXIS_Y,
        CFG_AXIS_Z,
        CFG_RADIUS
    } t_cfg_idx;

    function automatic t_q f_clamp(input logic signed [QW:0] v);
        t_q res;
        if (v > LIM_W) begin
            res = Q_LIM;
        end else if (v < -LIM_W) begin
            res = -Q_LIM;
        end else begin
            res = v[QW-1:0];
        end
        return res;
    endfunction

    function automatic t_q f_add(input t_q a, input t_q b);
        logic signed [QW:0] s;
        s = {a[QW-1], a} + {b[QW-1], b};
        return f_clamp(s);
    endfunction

    function automatic t_q f_sub(input t_q a, input t_q b);
        logic signed [QW:0] s;
        s = {a[QW-1], a} - {b[QW-1], b};
        return f_clamp(s);
    endfunction

endpackage

/* rtl/ray_cylinder_intersect.sv */
// top level: ray against infinite cylinder, fixed-point pipeline with output skid
//
// channel   direction  handshake            payload
// -------   ---------  -------------------  ------------------------------------------
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
// ray       in         i_valid / o_ready    i_origin_x/y/z, i_dir_x/y/z, i_nearest_in
// result    out        o_valid / i_ready    o_nearest_out, o_hit
//
// one ray per cycle sustained while o_ready is high
// latency is set by the pipelined digit-by-digit square root and the two pipelined dividers
// synchronous active-low reset clears valid bits and loads the config defaults
// a stalled result holds in the output register; a second one goes to the skid
// stage, and only then does the whole pipeline freeze and o_ready drop
module ray_cylinder_intersect #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rcy_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [((COORD_WIDTH > FRAC_BITS + 2) ? COORD_WIDTH : FRAC_BITS + 2)-1:0]
                                                 i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [COORD_WIDTH-1:0]        i_origin_x,
    input  logic signed [COORD_WIDTH-1:0]        i_origin_y,
    input  logic signed [COORD_WIDTH-1:0]        i_origin_z,
    input  logic signed [FRAC_BITS+1:0]          i_dir_x,
    input  logic signed [FRAC_BITS+1:0]          i_dir_y,
    input  logic signed [FRAC_BITS+1:0]          i_dir_z,
    input  logic [COORD_WIDTH-2:0]               i_nearest_in,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [COORD_WIDTH-2:0]               o_nearest_out,
    output logic                                 o_hit
);
    import rcy_pkg::*;

    localparam int DW  = FRAC_BITS + 2;
    localparam int CW  = COORD_WIDTH;
    localparam int SQ  = (((64 + FRAC_BITS) + 1) / 2 * 2) / 2;
    localparam int DL  = 63 + FRAC_BITS + 1;
    localparam int LAT = 15 + SQ + DL;

    localparam t_q            EPS_Q    = t_q'((64'd1 << FRAC_BITS) / 100);
    localparam logic [DW-1:0] AXIS_ONE = DW'(1) << FRAC_BITS;
    localparam logic [CW-2:0] RAD_ONE  = (CW-1)'(1) << FRAC_BITS;

    // config registers; the user must keep them static while rays are in flight, the block does not enforce it
    logic signed [CW-1:0] r_center [3];
    logic signed [DW-1:0] r_axis   [3];
    logic [CW-2:0]        r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
            r_axis[0]   <= '0;
            r_axis[1]   <= AXIS_ONE;
            r_axis[2]   <= '0;
            r_radius    <= RAD_ONE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X: r_center[0] <= i_cfg_data[CW-1:0];
                CFG_CENTER_Y: r_center[1] <= i_cfg_data[CW-1:0];
                CFG_CENTER_Z: r_center[2] <= i_cfg_data[CW-1:0];
                CFG_AXIS_X:   r_axis[0]   <= i_cfg_data[DW-1:0];
                CFG_AXIS_Y:   r_axis[1]   <= i_cfg_data[DW-1:0];
                CFG_AXIS_Z:   r_axis[2]   <= i_cfg_data[DW-1:0];
                CFG_RADIUS:   r_radius    <= i_cfg_data[CW-2:0];
                default: ;
            endcase
        end
    end

    // pipeline advances whenever the skid stage is free
    logic             en;
    logic [LAT-1:0]   r_vld;
    logic             r_out_vld, r_skid_vld;
    logic [CW-2:0]    r_out_near, r_skid_near;
    logic             r_out_hit, r_skid_hit;

    assign en      = !r_skid_vld;
    assign o_ready = en;

    // sign-extended operands, radius zero-extended
    t_q ax_q [3];
    t_q in_o [3];
    t_q in_d [3];
    t_q cen_q [3];
    t_q rad_q;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ax_q[i]  = {{(QW-DW){r_axis[i][DW-1]}}, r_axis[i]};
            cen_q[i] = {{(QW-CW){r_center[i][CW-1]}}, r_center[i]};
        end
        in_o[0] = {{(QW-CW){i_origin_x[CW-1]}}, i_origin_x};
        in_o[1] = {{(QW-CW){i_origin_y[CW-1]}}, i_origin_y};
        in_o[2] = {{(QW-CW){i_origin_z[CW-1]}}, i_origin_z};
        in_d[0] = {{(QW-DW){i_dir_x[DW-1]}}, i_dir_x};
        in_d[1] = {{(QW-DW){i_dir_y[DW-1]}}, i_dir_y};
        in_d[2] = {{(QW-DW){i_dir_z[DW-1]}}, i_dir_z};
        rad_q   = signed'(QW'(r_radius));
    end

    // stage 1: offset from axis point
    t_q r1_op [3];
    t_q r1_dp [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_op[i] <= f_sub(in_o[i], cen_q[i]);
                r1_dp[i] <= in_d[i];
            end
        end
    end

    // stages 2-3: projections onto the axis
    t_q m1_d [3];
    t_q m1_o [3];

    for (genvar i = 0; i < 3; i++) begin : g_m1
        rcy_qmul #(.FRAC_BITS(FRAC_BITS)) u_md (
            .i_clk(i_clk), .i_en(en), .i_a(r1_dp[i]), .i_b(ax_q[i]), .o_p(m1_d[i])
        );
        rcy_qmul #(.FRAC_BITS(FRAC_BITS)) u_mo (
            .i_clk(i_clk), .i_en(en), .i_a(r1_op[i]), .i_b(ax_q[i]), .o_p(m1_o[i])
        );
    end

    // stage 4: axial components
    t_q r4_dd, r4_od;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_dd <= f_add(f_add(m1_d[0], m1_d[1]), m1_d[2]);
            r4_od <= f_add(f_add(m1_o[0], m1_o[1]), m1_o[2]);
        end
    end

    // stages 5-6: axial vectors, ray vectors delayed alongside
    t_q m2_d [3];
    t_q m2_o [3];
    logic [6*QW-1:0] vec_dly;

    for (genvar i = 0; i < 3; i++) begin : g_m2
        rcy_qmul #(.FRAC_BITS(FRAC_BITS)) u_md (
            .i_clk(i_clk), .i_en(en), .i_a(r4_dd), .i_b(ax_q[i]), .o_p(m2_d[i])
        );
        rcy_qmul #(.FRAC_BITS(FRAC_BITS)) u_mo (
            .i_clk(i_clk), .i_en(en), .i_a(r4_od), .i_b(ax_q[i]), .o_p(m2_o[i])
        );
    end

    rcy_delay #(.WIDTH(6*QW), .DEPTH(5)) u_vec_dly (
        .i_clk(i_clk), .i_en(en),
        .i_d({r1_dp[0], r1_dp[1], r1_dp[2], r1_op[0], r1_op[1], r1_op[2]}),
        .o_q(vec_dly)
    );

    // stage 7: remove axial components
    t_q r7_dp [3];
    t_q r7_op [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r7_dp[i] <= f_sub(vec_dly[(5-i)*QW +: QW], m2_d[i]);
                r7_op[i] <= f_sub(vec_dly[(2-i)*QW +: QW], m2_o[i]);
            end
        end
    end

    // stages 8-9: quadratic coefficient products
    t_q m3_a [3];
    t_q m3_b [3];
    t_q m3_c [3];
    t_q m3_rr;

    for (genvar i = 0; i < 3; i++) begin : g_m3
        rcy_qmul #(.FRAC_BITS(FRAC_BITS)) u_ma (
            .i_clk(i_clk), .i_en(en), .i_a(r7_dp[i]), .i_b(r7_dp[i]), .o_p(m3_a[i])
        );
        rcy_qmul #(.FRAC_BITS(FRAC_BITS)) u_mb (
            .i_clk(i_clk), .i_en(en), .i_a(r7_dp[i]), .i_b(r7_op[i]), .o_p(m3_b[i])
        );
        rcy_qmul #(.FRAC_BITS(FRAC_BITS)) u_mc (
            .i_clk(i_clk), .i_en(en), .i_a(r7_op[i]), .i_b(r7_op[i]), .o_p(m3_c[i])
        );
    end

    rcy_qmul #(.FRAC_BITS(FRAC_BITS)) u_mrr (
        .i_clk(i_clk), .i_en(en), .i_a(rad_q), .i_b(rad_q), .o_p(m3_rr)
    );

    // stages 10-11: a, b, c
    t_q r10_a, r10_bs, r10_cs, r10_rr;
    t_q r11_a, r11_b, r11_c;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_a  <= f_add(f_add(m3_a[0], m3_a[1]), m3_a[2]);
            r10_bs <= f_add(f_add(m3_b[0], m3_b[1]), m3_b[2]);
            r10_cs <= f_add(f_add(m3_c[0], m3_c[1]), m3_c[2]);
            r10_rr <= m3_rr;
            r11_a  <= r10_a;
            r11_b  <= f_add(r10_bs, r10_bs);
            r11_c  <= f_sub(r10_cs, r10_rr);
        end
    end

    // stages 12-13: a*c and b*b
    t_q m4_ac, m4_bb;
    logic [2*QW-1:0] ab_dly;

    rcy_qmul #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk(i_clk), .i_en(en), .i_a(r11_a), .i_b(r11_c), .o_p(m4_ac)
    );
    rcy_qmul #(.FRAC_BITS(FRAC_BITS)) u_mbb (
        .i_clk(i_clk), .i_en(en), .i_a(r11_b), .i_b(r11_b), .o_p(m4_bb)
    );
    rcy_delay #(.WIDTH(2*QW), .DEPTH(2)) u_ab_dly (
        .i_clk(i_clk), .i_en(en), .i_d({r11_a, r11_b}), .o_q(ab_dly)
    );

    // stage 14: discriminant, denominator, root exists flag
    t_q   ac2, n_disc, dly_a, dly_b;
    t_q   r14_disc, r14_den, r14_b;
    logic r14_ok;

    always_comb begin
        dly_a  = ab_dly[2*QW-1:QW];
        dly_b  = ab_dly[QW-1:0];
        ac2    = f_add(m4_ac, m4_ac);
        n_disc = f_sub(m4_bb, f_add(ac2, ac2));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r14_disc <= n_disc;
            r14_den  <= f_add(dly_a, dly_a);
            r14_b    <= dly_b;
            // negative discriminant or ray parallel to axis: no root
            r14_ok   <= !n_disc[QW-1] && (dly_a > 0);
        end
    end

    // square root, with b, den and flag riding alongside
    t_q              sq_root;
    logic [2*QW:0]   sq_side;

    rcy_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_v(unsigned'(r14_disc)), .o_root(sq_root)
    );
    rcy_delay #(.WIDTH(2*QW+1), .DEPTH(SQ)) u_sq_dly (
        .i_clk(i_clk), .i_en(en), .i_d({r14_den, r14_b, r14_ok}), .o_q(sq_side)
    );

    // numerators of both roots
    t_q   neg_b, r_t1n, r_t2n, r_den;
    logic r_ok;

    assign neg_b = f_sub('0, sq_side[QW:1]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1n <= f_add(neg_b, sq_root);
            r_t2n <= f_sub(neg_b, sq_root);
            r_den <= sq_side[2*QW:QW+1];
            r_ok  <= sq_side[0];
        end
    end

    // both roots divided in parallel
    t_q            t1, t2;
    logic          ok_dly;
    logic [CW-2:0] near_dly;

    rcy_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
        .i_clk(i_clk), .i_en(en), .i_num(r_t1n), .i_den(r_den), .o_q(t1)
    );
    rcy_div #(.FRAC_BITS(FRAC_BITS)) u_div2 (
        .i_clk(i_clk), .i_en(en), .i_num(r_t2n), .i_den(r_den), .o_q(t2)
    );
    rcy_delay #(.WIDTH(1), .DEPTH(DL)) u_ok_dly (
        .i_clk(i_clk), .i_en(en), .i_d(r_ok), .o_q(ok_dly)
    );
    rcy_delay #(.WIDTH(CW-1), .DEPTH(LAT)) u_near_dly (
        .i_clk(i_clk), .i_en(en), .i_d(i_nearest_in), .o_q(near_dly)
    );

    // root choice: smaller root unless it lies behind the origin
    t_q            lo_r, hi_r, root, near_q;
    logic          n_hit;
    logic [CW-2:0] n_near;

    always_comb begin
        lo_r   = (t1 < t2) ? t1 : t2;
        hi_r   = (t1 < t2) ? t2 : t1;
        root   = lo_r[QW-1] ? hi_r : lo_r;
        near_q = signed'(QW'(near_dly));
        // root equal to nearest still counts as a hit
        n_hit  = ok_dly && (root > EPS_Q) && (root <= near_q);
        n_near = n_hit ? root[CW-2:0] : near_dly;
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // output register and skid stage
    logic deliver, take;

    assign deliver = en && r_vld[LAT-1];
    assign take    = r_out_vld && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (r_skid_vld) begin
                if (take) begin
                    r_out_near <= r_skid_near;
                    r_out_hit  <= r_skid_hit;
                    r_skid_vld <= 1'b0;
                end
            end else if (deliver) begin
                if (!r_out_vld || take) begin
                    r_out_near <= n_near;
                    r_out_hit  <= n_hit;
                    r_out_vld  <= 1'b1;
                end else begin
                    r_skid_near <= n_near;
                    r_skid_hit  <= n_hit;
                    r_skid_vld  <= 1'b1;
                end
            end else if (take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_vld;
    assign o_nearest_out = r_out_near;
    assign o_hit         = r_out_hit;

    // skid holds a transaction only behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid stage valid with empty output register");

    // skid fills or stays only across an output stall
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> $past(r_out_vld && !i_ready))
        else $error("skid stage valid without a preceding output stall");

    // a hit distance is always beyond the near threshold
    a_hit_past_eps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_hit) |-> (signed'(QW'(r_out_near)) > EPS_Q))
        else $error("hit reported at a distance inside the threshold");

endmodule

/* rtl/rcy_delay.sv */
// enable-gated delay line for side data that travels with the pipeline
module rcy_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_sr [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_q = r_sr[DEPTH-1];
endmodule

/* rtl/rcy_qmul.sv */
// two-stage saturating fixed-point multiplier built from four 32x32 partial products
module rcy_qmul #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  rcy_pkg::t_q  i_a,
    input  rcy_pkg::t_q  i_b,
    output rcy_pkg::t_q  o_p
);
    import rcy_pkg::*;

    logic [QW-1:0]  ua, ub;
    logic [63:0]    r_p00, r_p01, r_p10, r_p11;
    logic           r_neg;
    logic [127:0]   prod;
    logic           sat;
    logic [QW-1:0]  pmag;
    t_q             smag, n_p, r_p;

    assign ua = i_a[QW-1] ? unsigned'(-i_a) : unsigned'(i_a);
    assign ub = i_b[QW-1] ? unsigned'(-i_b) : unsigned'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= ua[31:0]  * ub[31:0];
            r_p01 <= ua[31:0]  * ub[63:32];
            r_p10 <= ua[63:32] * ub[31:0];
            r_p11 <= ua[63:32] * ub[63:32];
            r_neg <= i_a[QW-1] ^ i_b[QW-1];
        end
    end

    always_comb begin
        prod = {64'b0, r_p00} + {32'b0, r_p01, 32'b0} + {32'b0, r_p10, 32'b0}
             + {r_p11, 64'b0};
        sat  = |prod[127:64+FRAC_BITS];
        pmag = prod[FRAC_BITS +: QW];
        smag = (sat || (pmag > unsigned'(Q_LIM))) ? Q_LIM : signed'(pmag);
        n_p  = r_neg ? -smag : smag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;
endmodule

/* rtl/rcy_sqrt.sv */
// pipelined digit-by-digit square root, one result bit per stage
module rcy_sqrt #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [63:0]  i_v,
    output rcy_pkg::t_q  o_root
);
    import rcy_pkg::*;

    localparam int TOT = ((64 + FRAC_BITS) + 1) / 2 * 2;
    localparam int SQ  = TOT / 2;
    localparam int RW  = SQ + 3;

    logic [TOT-1:0] x0;
    logic [TOT-1:0] r_x    [SQ-1];
    logic [RW-1:0]  r_rem  [SQ-1];
    logic [SQ-1:0]  r_root [SQ];

    assign x0 = TOT'({i_v, {FRAC_BITS{1'b0}}});

    for (genvar k = 0; k < SQ; k++) begin : g_st
        logic [TOT-1:0] x_in;
        logic [RW-1:0]  rem_in, rem_s, t_v;
        logic [SQ-1:0]  root_in;
        logic           ge;

        if (k == 0) begin : g_first
            assign x_in    = x0;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign x_in    = r_x[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        assign rem_s = {rem_in[RW-3:0], x_in[TOT-1 -: 2]};
        assign t_v   = RW'({root_in, 2'b01});
        assign ge    = rem_s >= t_v;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= {root_in[SQ-2:0], ge};
            end
        end

        if (k < SQ - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k]   <= x_in << 2;
                    r_rem[k] <= ge ? rem_s - t_v : rem_s;
                end
            end
        end
    end

    assign o_root = signed'(QW'(r_root[SQ-1]));
endmodule

/* rtl/rcy_div.sv */
// pipelined restoring divider, num * 2^frac / den, one quotient bit per stage
module rcy_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  rcy_pkg::t_q  i_num,
    input  rcy_pkg::t_q  i_den,
    output rcy_pkg::t_q  o_q
);
    import rcy_pkg::*;

    localparam int NB = 63 + FRAC_BITS;

    logic [QW-1:0]  nmag;
    logic [NB-1:0]  r_x   [NB];
    logic [63:0]    r_rem [NB-1];
    logic [63:0]    r_d   [NB-1];
    logic           r_neg [NB];
    logic [NB-1:0]  qv;
    t_q             smag, r_q;

    assign nmag = i_num[QW-1] ? unsigned'(-i_num) : unsigned'(i_num);

    for (genvar k = 0; k < NB; k++) begin : g_st
        logic [NB-1:0] x_in;
        logic [63:0]   rem_in, rem_s, d_in;
        logic          neg_in, ge;

        if (k == 0) begin : g_first
            assign x_in   = {nmag[62:0], {FRAC_BITS{1'b0}}};
            assign rem_in = '0;
            assign d_in   = {1'b0, i_den[62:0]};
            assign neg_in = i_num[QW-1];
        end else begin : g_next
            assign x_in   = r_x[k-1];
            assign rem_in = r_rem[k-1];
            assign d_in   = r_d[k-1];
            assign neg_in = r_neg[k-1];
        end

        assign rem_s = {rem_in[62:0], x_in[NB-1]};
        assign ge    = rem_s >= d_in;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]   <= {x_in[NB-2:0], ge};
                r_neg[k] <= neg_in;
            end
        end

        if (k < NB - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? rem_s - d_in : rem_s;
                    r_d[k]   <= d_in;
                end
            end
        end
    end

    // quotient above the saturation limit clamps
    assign qv   = r_x[NB-1];
    assign smag = (|qv[NB-1:62]) ? Q_LIM : signed'({1'b0, qv[62:0]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= r_neg[NB-1] ? -smag : smag;
        end
    end

    assign o_q = r_q;
endmodule
